/* hdl/bdgr_pkg.sv */
// ----------------------------------------------------------------------------
// bdgr_pkg
// Shared constants, types and fixed-point helpers of the band delay mixer.
// ----------------------------------------------------------------------------
package bdgr_pkg;

  localparam int LOW_DELAY  = 72;
  localparam int MID_DELAY  = 60;
  localparam int HIGH_DELAY = 276;

  localparam int LOW_AW  = (LOW_DELAY  > 1) ? $clog2(LOW_DELAY)  : 1;
  localparam int MID_AW  = (MID_DELAY  > 1) ? $clog2(MID_DELAY)  : 1;
  localparam int HIGH_AW = (HIGH_DELAY > 1) ? $clog2(HIGH_DELAY) : 1;

  localparam int CURVE_LEN = 66;
  localparam int CURVE_AW  = 7;
  localparam logic [CURVE_AW-1:0] CURVE_CLIP_A = 7'd64;
  localparam logic [CURVE_AW-1:0] CURVE_CLIP_B = 7'd65;

  // One third in 17-bit reciprocal form, exact for values below 2^17.
  localparam logic [16:0] RECIP3 = 17'd43691;

  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_COEF_LOW     = 3'd0;
  localparam logic [2:0] REG_COEF_MID     = 3'd1;
  localparam logic [2:0] REG_COEF_HIGH    = 3'd2;
  localparam logic [2:0] REG_COEF_DETECT  = 3'd3;
  localparam logic [2:0] REG_COEF_AIR     = 3'd4;
  localparam logic [2:0] REG_REPAIR_ON    = 3'd5;
  localparam logic [2:0] REG_STRICT_MODE  = 3'd6;
  localparam logic [2:0] REG_SMP_FRACTION = 3'd7;

  localparam logic [30:0] COEF_LOW_RST     = 31'd7791316;
  localparam logic [30:0] COEF_MID_RST     = 31'd24347867;
  localparam logic [30:0] COEF_HIGH_RST    = 31'd56000136;
  localparam logic [30:0] COEF_DETECT_RST  = 31'd536870912;
  localparam logic [30:0] COEF_AIR_RST     = 31'd973915441;
  localparam logic [4:0]  SMP_FRACTION_RST = 5'd28;

  // Pipeline tag: a word is present, and it is a table write.
  typedef struct packed {
    logic valid;
    logic tab;
  } tag_t;

  // Per-sample values that ride along through the gain lookup.
  typedef struct packed {
    logic [31:0] tl;
    logic [31:0] tr;
    logic [31:0] al;
    logic [31:0] ar;
  } carry_t;

  function automatic logic [31:0] fmul31(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[62:31];
  endfunction

  function automatic logic [31:0] fmul24(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[55:24];
  endfunction

endpackage

/* hdl/bdgr_band.sv */
// ----------------------------------------------------------------------------
// bdgr_band
// Band split, three circular delay lines and the four-band sum.
// ----------------------------------------------------------------------------
module bdgr_band import bdgr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  tag_t        tag_in,
  input  logic [31:0] xl,
  input  logic [31:0] xr,
  input  logic [6:0]  tidx_in,
  input  logic [24:0] tval_in,
  input  logic [30:0] coef_low,
  input  logic [30:0] coef_mid,
  input  logic [30:0] coef_high,
  output tag_t        tag_out,
  output logic [31:0] tl,
  output logic [31:0] tr,
  output logic [6:0]  tidx_out,
  output logic [24:0] tval_out
);

  tag_t        tag1, tag2, tag3;
  logic [31:0] x1l, x1r, x2l, x2r;
  logic [6:0]  tidx1, tidx2, tidx3;
  logic [24:0] tval1, tval2, tval3;
  logic [31:0] m1l, m2l, m3l, m1r, m2r, m3r;
  logic [31:0] b1l, b1r;
  logic [63:0] lo_rd, mid_rd, hi_rd;
  logic        lo_ok, mid_ok, hi_ok;

  logic [63:0] lo_mem  [LOW_DELAY];
  logic [63:0] mid_mem [MID_DELAY];
  logic [63:0] hi_mem  [HIGH_DELAY];

  logic [LOW_AW-1:0]  lo_pos;
  logic [MID_AW-1:0]  mid_pos;
  logic [HIGH_AW-1:0] hi_pos;
  logic               lo_wrap, mid_wrap, hi_wrap;
  logic               smp2;

  assign smp2 = tag2.valid && !tag2.tab;

  // Stage 1: input register.  Stage 2: the three band products.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
    end else if (adv) begin
      tag1 <= tag_in;
      tag2 <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1l   <= xl;
      x1r   <= xr;
      tidx1 <= tidx_in;
      tval1 <= tval_in;
      x2l   <= x1l;
      x2r   <= x1r;
      tidx2 <= tidx1;
      tval2 <= tval1;
      m1l   <= fmul31(x1l, {1'b0, coef_low});
      m2l   <= fmul31(x1l, {1'b0, coef_mid});
      m3l   <= fmul31(x1l, {1'b0, coef_high});
      m1r   <= fmul31(x1r, {1'b0, coef_low});
      m2r   <= fmul31(x1r, {1'b0, coef_mid});
      m3r   <= fmul31(x1r, {1'b0, coef_high});
    end
  end

  // Stage 3: each line reads its oldest entry and overwrites it in the same cycle.
  always_ff @(posedge clk) begin
    if (adv && smp2) begin
      lo_rd  <= lo_mem[lo_pos];
      mid_rd <= mid_mem[mid_pos];
      hi_rd  <= hi_mem[hi_pos];
      lo_mem[lo_pos]   <= {x2r - m1r, x2l - m1l};
      mid_mem[mid_pos] <= {m2r - m3r, m2l - m3l};
      hi_mem[hi_pos]   <= {m3r, m3l};
    end
  end

  // An entry holds real data only once its line has wrapped at least once.
  always_ff @(posedge clk) begin
    if (rst) begin
      lo_pos   <= '0;
      mid_pos  <= '0;
      hi_pos   <= '0;
      lo_wrap  <= 1'b0;
      mid_wrap <= 1'b0;
      hi_wrap  <= 1'b0;
      tag3     <= '0;
      tag_out  <= '0;
    end else if (adv) begin
      tag3    <= tag2;
      tag_out <= tag3;
      if (smp2) begin
        if (lo_pos == LOW_AW'(LOW_DELAY - 1)) begin
          lo_pos  <= '0;
          lo_wrap <= 1'b1;
        end else begin
          lo_pos <= lo_pos + 1'b1;
        end
        if (mid_pos == MID_AW'(MID_DELAY - 1)) begin
          mid_pos  <= '0;
          mid_wrap <= 1'b1;
        end else begin
          mid_pos <= mid_pos + 1'b1;
        end
        if (hi_pos == HIGH_AW'(HIGH_DELAY - 1)) begin
          hi_pos  <= '0;
          hi_wrap <= 1'b1;
        end else begin
          hi_pos <= hi_pos + 1'b1;
        end
      end
    end
  end

  // Stage 4: the band sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      b1l    <= m1l - m2l;
      b1r    <= m1r - m2r;
      lo_ok  <= lo_wrap;
      mid_ok <= mid_wrap;
      hi_ok  <= hi_wrap;
      tidx3  <= tidx2;
      tval3  <= tval2;
      tidx_out <= tidx3;
      tval_out <= tval3;
      tl <= b1l + (lo_ok ? lo_rd[31:0] : 32'd0) + (mid_ok ? mid_rd[31:0] : 32'd0)
               + (hi_ok ? hi_rd[31:0] : 32'd0);
      tr <= b1r + (lo_ok ? lo_rd[63:32] : 32'd0) + (mid_ok ? mid_rd[63:32] : 32'd0)
               + (hi_ok ? hi_rd[63:32] : 32'd0);
    end
  end

  a_lo_range : assert property (@(posedge clk) disable iff (rst)
    lo_pos <= LOW_AW'(LOW_DELAY - 1)) else $error("low line position out of range");
  a_mid_range : assert property (@(posedge clk) disable iff (rst)
    mid_pos <= MID_AW'(MID_DELAY - 1)) else $error("mid line position out of range");
  a_hi_range : assert property (@(posedge clk) disable iff (rst)
    hi_pos <= HIGH_AW'(HIGH_DELAY - 1)) else $error("high line position out of range");
  a_reset : assert property (@(posedge clk)
    rst |=> (lo_pos == '0 && mid_pos == '0 && hi_pos == '0 && !lo_wrap && !hi_wrap))
    else $error("delay lines not cleared by reset");
  a_hold : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(lo_pos) && $stable(hi_pos)) else $error("position moved in a stall");

endmodule

/* hdl/bdgr_gain.sv */
// ----------------------------------------------------------------------------
// bdgr_gain
// Gain curve store and lookup with linear interpolation and clipped region.
// ----------------------------------------------------------------------------
module bdgr_gain import bdgr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  tag_t        tag_in,
  input  logic [31:0] big,
  input  logic [6:0]  tidx,
  input  logic [24:0] tval,
  input  carry_t      carry_in,
  input  logic [4:0]  smp_fraction,
  output tag_t        tag_out,
  output logic        ok_out,
  output logic [31:0] gain,
  output carry_t      carry_out
);

  logic [24:0] curve [CURVE_LEN];

  logic [30:0] v0;
  logic [45:0] v;
  tag_t        tag7, tag8, tag9;
  carry_t      c7, c8, c9;
  logic        reg0, ok7, ok8, ok9;
  logic [5:0]  idx;
  logic [8:0]  rem;
  logic [16:0] n;
  logic [6:0]  tidx7;
  logic [24:0] tval7;
  logic [33:0] q3;
  logic [CURVE_AW-1:0] a0, a1;
  logic [30:0] frac;
  logic [24:0] g0, g1, g0_9;
  logic [31:0] prod;

  // A negative sample s is folded to -(s+1), which is its bitwise inverse.
  always_comb begin
    v0 = big[31] ? ~big[30:0] : big[30:0];
    if (smp_fraction > 5'd15) v = {15'd0, v0} >> (smp_fraction - 5'd15);
    else                      v = {15'd0, v0} << (5'd15 - smp_fraction);
  end

  // Stage 1: region and index.
  always_ff @(posedge clk) begin
    if (adv) begin
      reg0  <= (v[45:15] == '0);
      ok7   <= (v[45:17] == '0);
      idx   <= v[14:9];
      rem   <= v[8:0];
      n     <= v[16:0] - 17'd32768;
      tidx7 <= tidx;
      tval7 <= tval;
      c7    <= carry_in;
    end
  end

  assign q3 = n * RECIP3;
  assign a0 = reg0 ? {1'b0, idx} : CURVE_CLIP_A;
  assign a1 = reg0 ? {1'b0, idx} + 1'b1 : CURVE_CLIP_B;

  // Stage 2: table writes, curve reads and the interpolation fraction.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (tag7.valid && tag7.tab && tidx7 < CURVE_AW'(CURVE_LEN)) begin
        curve[tidx7] <= tval7;
      end
      g0 <= curve[a0];
      g1 <= curve[a1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frac <= reg0 ? {rem, 22'd0} : {q3[31:17], 16'd0};
      ok8  <= ok7;
      c8   <= c7;
      prod <= fmul31({1'b0, frac}, {7'd0, g0} - {7'd0, g1});
      g0_9 <= g0;
      ok9  <= ok8;
      c9   <= c8;
      gain      <= {7'd0, g0_9} - prod;
      ok_out    <= ok9;
      carry_out <= c9;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag7    <= '0;
      tag8    <= '0;
      tag9    <= '0;
      tag_out <= '0;
    end else if (adv) begin
      tag7    <= tag_in;
      tag8    <= tag7;
      tag9    <= tag8;
      tag_out <= tag9;
    end
  end

endmodule

/* hdl/band_delay_gain_repair.sv */
// ----------------------------------------------------------------------------
// band_delay_gain_repair
// Stereo four-band delay mixer with a gain-curve driven repair add.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tuser: req_type; tdata: left, right, index, value
//  m_axis    out        tdata: left_out, right_out
//  apb       in/out     eight configuration registers at 4*i
//
// One word enters per cycle while m_axis is not stalled; each sample pair
// leaves after the chain of registered multiplies: band split, detect and
// air bands, interpolation and the final gain multiply.
// Reset is synchronous and clears the delay lines through their wrap flags.
// A stall on m_axis freezes the whole pipeline and drops s_axis_tready.
// ----------------------------------------------------------------------------
module band_delay_gain_repair import bdgr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [95:0]       s_axis_tdata,  // left_in, right_in, table_index, table_value
  input  logic [0:0]        s_axis_tuser,  // req_type
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [63:0]       m_axis_tdata,  // left_out, right_out
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [30:0] coef_low, coef_mid, coef_high, coef_detect, coef_air;
  logic        repair_on, strict_mode;
  logic [4:0]  smp_fraction;
  logic        adv;
  tag_t        tag_in, tag4, tag5, tag6, tag10, tag11;
  logic [31:0] tl4, tr4;
  logic [6:0]  tidx4, tidx5, tidx6;
  logic [24:0] tval4, tval5, tval6;
  logic [31:0] phl, pdl, pal, phr, pdr, par, t5l, t5r;
  logic [31:0] dl, dr, big;
  carry_t      c6, c10, c11;
  logic        ok10, ok11;
  logic [31:0] gain, ql, qr;
  logic [31:0] sl, sr;
  logic        skip;

  assign pready = 1'b1;
  assign adv    = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign tag_in = '{valid: s_axis_tvalid, tab: s_axis_tuser[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_low     <= COEF_LOW_RST;
      coef_mid     <= COEF_MID_RST;
      coef_high    <= COEF_HIGH_RST;
      coef_detect  <= COEF_DETECT_RST;
      coef_air     <= COEF_AIR_RST;
      repair_on    <= 1'b0;
      strict_mode  <= 1'b0;
      smp_fraction <= SMP_FRACTION_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_COEF_LOW:     coef_low     <= pwdata[30:0];
        REG_COEF_MID:     coef_mid     <= pwdata[30:0];
        REG_COEF_HIGH:    coef_high    <= pwdata[30:0];
        REG_COEF_DETECT:  coef_detect  <= pwdata[30:0];
        REG_COEF_AIR:     coef_air     <= pwdata[30:0];
        REG_REPAIR_ON:    repair_on    <= pwdata[0];
        REG_STRICT_MODE:  strict_mode  <= pwdata[0];
        REG_SMP_FRACTION: smp_fraction <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_COEF_LOW:     prdata = {1'b0, coef_low};
      REG_COEF_MID:     prdata = {1'b0, coef_mid};
      REG_COEF_HIGH:    prdata = {1'b0, coef_high};
      REG_COEF_DETECT:  prdata = {1'b0, coef_detect};
      REG_COEF_AIR:     prdata = {1'b0, coef_air};
      REG_REPAIR_ON:    prdata = {31'd0, repair_on};
      REG_STRICT_MODE:  prdata = {31'd0, strict_mode};
      REG_SMP_FRACTION: prdata = {27'd0, smp_fraction};
      default:          prdata = '0;
    endcase
  end

  bdgr_band u_band (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .tag_in    (tag_in),
    .xl        (s_axis_tdata[31:0]),
    .xr        (s_axis_tdata[63:32]),
    .tidx_in   (s_axis_tdata[70:64]),
    .tval_in   (s_axis_tdata[95:71]),
    .coef_low  (coef_low),
    .coef_mid  (coef_mid),
    .coef_high (coef_high),
    .tag_out   (tag4),
    .tl        (tl4),
    .tr        (tr4),
    .tidx_out  (tidx4),
    .tval_out  (tval4)
  );

  // Detect and air band products, then the larger detect band.
  always_ff @(posedge clk) begin
    if (adv) begin
      phl   <= fmul31(tl4, {1'b0, coef_high});
      pdl   <= fmul31(tl4, {1'b0, coef_detect});
      pal   <= fmul31(tl4, {1'b0, coef_air});
      phr   <= fmul31(tr4, {1'b0, coef_high});
      pdr   <= fmul31(tr4, {1'b0, coef_detect});
      par   <= fmul31(tr4, {1'b0, coef_air});
      t5l   <= tl4;
      t5r   <= tr4;
      tidx5 <= tidx4;
      tval5 <= tval4;
      big   <= ($signed(dl) > $signed(dr)) ? dl : dr;
      c6    <= '{tl: t5l, tr: t5r, al: pal, ar: par};
      tidx6 <= tidx5;
      tval6 <= tval5;
    end
  end

  assign dl = phl - pdl;
  assign dr = phr - pdr;

  bdgr_gain u_gain (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .tag_in       (tag6),
    .big          (big),
    .tidx         (tidx6),
    .tval         (tval6),
    .carry_in     (c6),
    .smp_fraction (smp_fraction),
    .tag_out      (tag10),
    .ok_out       (ok10),
    .gain         (gain),
    .carry_out    (c10)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ql   <= fmul24(gain, c10.al);
      qr   <= fmul24(gain, c10.ar);
      ok11 <= ok10;
      c11  <= c10;
    end
  end

  // Strict mode drops the add on both channels if either gain product plus its air band is -1.
  assign sl   = ql + c11.al;
  assign sr   = qr + c11.ar;
  assign skip = strict_mode && (sl == 32'hFFFF_FFFF || sr == 32'hFFFF_FFFF);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (repair_on && ok11 && !skip) m_axis_tdata <= {c11.tr + qr, c11.tl + ql};
      else                            m_axis_tdata <= {c11.tr, c11.tl};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag5          <= '0;
      tag6          <= '0;
      tag11         <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      tag5          <= tag4;
      tag6          <= tag5;
      tag11         <= tag10;
      m_axis_tvalid <= tag11.valid && !tag11.tab;
    end
  end

endmodule
